// ----- hw/rtl/deadline_timer_bank_assert.svh -----
// Assertion macros used by the checker file dtb_checker.sv.
`ifndef DEADLINE_TIMER_BANK_ASSERT_SVH
`define DEADLINE_TIMER_BANK_ASSERT_SVH

// Same-cycle implication.
`define DTB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define DTB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/dtb_pkg.sv -----
package dtb_pkg;

  localparam int NUM_SLOTS = 4;
  localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  typedef enum logic [1:0] {
    CMD_ARM_ONESHOT  = 2'd0,
    CMD_ARM_PERIODIC = 2'd1,
    CMD_CANCEL       = 2'd2,
    CMD_DISPATCH     = 2'd3
  } cmd_code_t;

  typedef enum logic [1:0] {
    KIND_ARMED   = 2'd0,
    KIND_FULL    = 2'd1,
    KIND_EXPIRED = 2'd2
  } kind_t;

  typedef struct packed {
    cmd_code_t   command;
    logic [31:0] current_time;
    logic [31:0] interval;
    logic [7:0]  slot_select;
    logic [7:0]  callback_tag;
  } item_t;

  typedef struct packed {
    kind_t      result_kind;
    logic [1:0] slot_index;
    logic [7:0] owner_tag;
    logic       last;
  } result_t;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

  typedef struct packed {
    alu_op_t     op;
    logic [31:0] a;
    logic [31:0] b;
  } alu_req_t;

  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] slot;
  } free_t;

  function automatic logic [1:0] slot_to_index(logic [SLOT_W-1:0] s);
    logic [31:0] w;
    w = 32'(s);
    return w[1:0];
  endfunction

endpackage

// ----- hw/rtl/deadline_timer_bank.sv -----
// deadline_timer_bank: a bank of NUM_SLOTS deadline timers under command control.
// Command channel: item is taken at a rising edge with start high and busy low.
// Result channel: result_strobe marks each result beat for exactly one cycle;
// the receiver cannot stall, so every beat must be taken when it is shown.
// Arm (one-shot or periodic): the item is registered into the arm state, which
// then registers one beat (armed or full), marked last.
// Cancel: handled at acceptance, busy never rises, no beat.
// Dispatch: busy while slots are checked and the final beat is flushed; each
// slot is visited once by the shared 32-bit add/subtract unit, which also
// takes one extra pass per due periodic slot to advance its due
// time. Expired beats come out in ascending slot order, the final one last.
// One item is in flight at a time; the sequencer and the single adder set the
// rate. Reset frees every slot and returns the block to idle at once.
module deadline_timer_bank (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  dtb_pkg::item_t   item,
  output logic             result_strobe,
  output dtb_pkg::result_t result
);
  import dtb_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE    = 5'b00001,
    ST_ARM     = 5'b00010,
    ST_CHECK   = 5'b00100,
    ST_ADVANCE = 5'b01000,
    ST_FLUSH   = 5'b10000
  } state_t;

  state_t               state;
  item_t                req;
  logic [NUM_SLOTS-1:0] active;
  logic [NUM_SLOTS-1:0] periodic;
  logic [31:0]          due    [NUM_SLOTS];
  logic [31:0]          period [NUM_SLOTS];
  logic [7:0]           tag    [NUM_SLOTS];
  logic [SLOT_W-1:0]    idx;
  logic                 pend_valid;
  logic [SLOT_W-1:0]    pend_slot;
  logic [7:0]           pend_tag;

  alu_req_t    alu_in;
  logic [31:0] alu_y;
  free_t       free;
  logic        hit;
  logic        last_slot;

  dtb_alu u_alu (
    .req (alu_in),
    .y   (alu_y)
  );

  dtb_free_find u_free (
    .active (active),
    .free   (free)
  );

  always_comb begin
    alu_in.op = ALU_ADD;
    alu_in.a  = req.current_time;
    alu_in.b  = req.interval;
    case (state)
      ST_CHECK: begin
        alu_in.op = ALU_SUB;
        alu_in.b  = due[idx];
      end
      ST_ADVANCE: begin
        alu_in.a = due[idx];
        alu_in.b = period[idx];
      end
      default: ;
    endcase
  end

  assign hit       = active[idx] && !alu_y[31];
  assign last_slot = (idx == SLOT_W'(NUM_SLOTS - 1));
  assign busy      = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      active        <= '0;
      pend_valid    <= 1'b0;
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            req <= item;
            case (item.command)
              CMD_ARM_ONESHOT, CMD_ARM_PERIODIC: begin
                state <= ST_ARM;
              end
              CMD_CANCEL: begin
                if (item.slot_select < 8'(NUM_SLOTS)) begin
                  active[item.slot_select[SLOT_W-1:0]] <= 1'b0;
                end
              end
              CMD_DISPATCH: begin
                idx        <= '0;
                pend_valid <= 1'b0;
                state      <= ST_CHECK;
              end
              default: ;
            endcase
          end
        end
        ST_ARM: begin
          result_strobe      <= 1'b1;
          result.owner_tag   <= req.callback_tag;
          result.last        <= 1'b1;
          if (free.found) begin
            active[free.slot]   <= 1'b1;
            periodic[free.slot] <= (req.command == CMD_ARM_PERIODIC);
            due[free.slot]      <= alu_y;
            period[free.slot]   <= (req.command == CMD_ARM_PERIODIC) ? req.interval : '0;
            tag[free.slot]      <= req.callback_tag;
            result.result_kind  <= KIND_ARMED;
            result.slot_index   <= slot_to_index(free.slot);
          end else begin
            result.result_kind <= KIND_FULL;
            result.slot_index  <= '0;
          end
          state <= ST_IDLE;
        end
        ST_CHECK: begin
          if (hit) begin
            if (pend_valid) begin
              result_strobe      <= 1'b1;
              result.result_kind <= KIND_EXPIRED;
              result.slot_index  <= slot_to_index(pend_slot);
              result.owner_tag   <= pend_tag;
              result.last        <= 1'b0;
            end
            pend_valid <= 1'b1;
            pend_slot  <= idx;
            pend_tag   <= tag[idx];
          end
          if (hit && periodic[idx]) begin
            state <= ST_ADVANCE;
          end else begin
            if (hit) begin
              active[idx] <= 1'b0;
            end
            if (last_slot) begin
              state <= ST_FLUSH;
            end else begin
              idx <= idx + SLOT_W'(1);
            end
          end
        end
        ST_ADVANCE: begin
          due[idx] <= alu_y;
          if (last_slot) begin
            state <= ST_FLUSH;
          end else begin
            idx   <= idx + SLOT_W'(1);
            state <= ST_CHECK;
          end
        end
        ST_FLUSH: begin
          if (pend_valid) begin
            result_strobe      <= 1'b1;
            result.result_kind <= KIND_EXPIRED;
            result.slot_index  <= slot_to_index(pend_slot);
            result.owner_tag   <= pend_tag;
            result.last        <= 1'b1;
          end
          pend_valid <= 1'b0;
          state      <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- hw/rtl/dtb_alu.sv -----
module dtb_alu (
  input  dtb_pkg::alu_req_t req,
  output logic [31:0]       y
);
  import dtb_pkg::*;

  always_comb begin
    if (req.op == ALU_SUB) begin
      y = req.a - req.b;
    end else begin
      y = req.a + req.b;
    end
  end

endmodule

// ----- hw/rtl/dtb_free_find.sv -----
module dtb_free_find (
  input  logic [dtb_pkg::NUM_SLOTS-1:0] active,
  output dtb_pkg::free_t                free
);
  import dtb_pkg::*;

  // Pick the lowest free slot.
  always_comb begin
    free.found = 1'b0;
    free.slot  = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (!active[i]) begin
        free.found = 1'b1;
        free.slot  = SLOT_W'(i);
      end
    end
  end

endmodule

// ----- hw/rtl/dtb_checker.sv -----
`include "deadline_timer_bank_assert.svh"

module dtb_checker (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input dtb_pkg::item_t   item,
  input logic             result_strobe,
  input dtb_pkg::result_t result
);
  import dtb_pkg::*;

  logic take;
  assign take = start && !busy;

  `DTB_ASSERT_NXT(a_cancel_silent, take && item.command == CMD_CANCEL, !result_strobe && !busy, "cancel gave a beat or went busy")
  `DTB_ASSERT_NXT(a_work_busy, take && item.command != CMD_CANCEL, busy, "accepted command did not raise busy")
  `DTB_ASSERT_IMP(a_arm_beat, take && (item.command == CMD_ARM_ONESHOT || item.command == CMD_ARM_PERIODIC), ##2 (result_strobe && result.last && result.result_kind != KIND_EXPIRED), "arm beat missing")
  `DTB_ASSERT_IMP(a_single_last, result_strobe && result.result_kind != KIND_EXPIRED, result.last, "arm beat not marked last")
  `DTB_ASSERT_NXT(a_quiet_after_last, result_strobe && result.last, !result_strobe, "beat after last")

endmodule

bind deadline_timer_bank dtb_checker u_dtb_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .item          (item),
  .result_strobe (result_strobe),
  .result        (result)
);

// ----- verif/timer_event_checker.sv -----
module timer_event_checker
  import dtb_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  logic    busy,
  input  item_t   item,
  input  logic    result_strobe,
  input  result_t result,
  output int      mismatches,
  output int      outstanding
);

  logic        slot_armed [NUM_SLOTS];
  logic        slot_repeats [NUM_SLOTS];
  logic [31:0] slot_deadline [NUM_SLOTS];
  logic [31:0] slot_reload [NUM_SLOTS];
  logic [7:0]  slot_owner [NUM_SLOTS];

  result_t timer_events_q [$];
  result_t want;
  int      error_total = 0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
    $display("%0t mismatch %s: got %0h, expected %0h", $time, what, got, exp_val);
    error_total++;
  endtask

  task automatic push_beat(input kind_t kind, input int slot, input logic [7:0] tag,
                           input logic fin);
    result_t beat;
    beat.result_kind = kind;
    beat.slot_index  = 2'(slot);
    beat.owner_tag   = tag;
    beat.last        = fin;
    timer_events_q.push_back(beat);
  endtask

  task automatic apply_timer_command(input item_t cmd_item);
    int          i;
    int          free_slot;
    int          held_slot;
    logic [31:0] lag;
    free_slot = -1;
    held_slot = -1;
    case (cmd_item.command)
      CMD_ARM_ONESHOT, CMD_ARM_PERIODIC: begin
        for (i = 0; i < NUM_SLOTS; i++)
          if (!slot_armed[i] && free_slot < 0) free_slot = i;
        if (free_slot >= 0) begin
          slot_armed[free_slot]    = 1'b1;
          slot_repeats[free_slot]  = (cmd_item.command == CMD_ARM_PERIODIC);
          slot_deadline[free_slot] = cmd_item.current_time + cmd_item.interval;
          slot_reload[free_slot]   = (cmd_item.command == CMD_ARM_PERIODIC) ?
                                     cmd_item.interval : 32'd0;
          slot_owner[free_slot]    = cmd_item.callback_tag;
          push_beat(KIND_ARMED, free_slot, cmd_item.callback_tag, 1'b1);
        end else begin
          push_beat(KIND_FULL, 0, cmd_item.callback_tag, 1'b1);
        end
      end
      CMD_CANCEL: begin
        if (cmd_item.slot_select < NUM_SLOTS) slot_armed[cmd_item.slot_select] = 1'b0;
      end
      default: begin
        for (i = 0; i < NUM_SLOTS; i++) begin
          lag = cmd_item.current_time - slot_deadline[i];
          if (slot_armed[i] && !lag[31]) begin
            // hold each beat until the next one shows whether it is the final one
            if (held_slot >= 0) push_beat(KIND_EXPIRED, held_slot, slot_owner[held_slot], 1'b0);
            held_slot = i;
            if (slot_repeats[i]) slot_deadline[i] = slot_deadline[i] + slot_reload[i];
            else slot_armed[i] = 1'b0;
          end
        end
        if (held_slot >= 0) push_beat(KIND_EXPIRED, held_slot, slot_owner[held_slot], 1'b1);
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_armed[i]    = 1'b0;
        slot_repeats[i]  = 1'b0;
        slot_deadline[i] = 32'd0;
        slot_reload[i]   = 32'd0;
        slot_owner[i]    = 8'd0;
      end
      timer_events_q.delete();
    end else begin
      if (result_strobe) begin
        if (timer_events_q.size() == 0) begin
          report_mismatch("unexpected beat", 32'(result), 32'd0);
        end else begin
          want = timer_events_q.pop_front();
          if (result.result_kind !== want.result_kind)
            report_mismatch("result_kind", 32'(result.result_kind), 32'(want.result_kind));
          if (result.slot_index !== want.slot_index)
            report_mismatch("slot_index", 32'(result.slot_index), 32'(want.slot_index));
          if (result.owner_tag !== want.owner_tag)
            report_mismatch("owner_tag", 32'(result.owner_tag), 32'(want.owner_tag));
          if (result.last !== want.last)
            report_mismatch("last", 32'(result.last), 32'(want.last));
        end
      end
      if (start && !busy) apply_timer_command(item);
    end
    outstanding <= timer_events_q.size();
    mismatches  <= error_total;
  end

endmodule

// ----- verif/tb_top.sv -----
module tb_top;
  import dtb_pkg::*;

  localparam int RANDOM_ITEMS = 250;
  localparam int CYCLE_LIMIT  = 100000;

  logic    clk;
  logic    rst;
  logic    start = 1'b0;
  item_t   item = '0;
  logic    busy;
  logic    result_strobe;
  result_t result;
  int      mismatches;
  int      outstanding;
  int      cycles = 0;

  logic [31:0] now_ticks;
  int          issued;
  int          pick;
  logic        calm;
  item_t       next_item;

  deadline_timer_bank u_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .item          (item),
    .result_strobe (result_strobe),
    .result        (result)
  );

  timer_event_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .item          (item),
    .result_strobe (result_strobe),
    .result        (result),
    .mismatches    (mismatches),
    .outstanding   (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic drive_beat(input item_t beat);
    start <= 1'b1;
    item  <= beat;
    do @(posedge clk); while (busy);
  endtask

  task automatic issue(input cmd_code_t cmd, input logic [31:0] t, input logic [31:0] ivl,
                       input logic [7:0] sel, input logic [7:0] tag);
    item_t beat;
    beat.command      = cmd;
    beat.current_time = t;
    beat.interval     = ivl;
    beat.slot_select  = sel;
    beat.callback_tag = tag;
    drive_beat(beat);
  endtask

  task automatic maybe_idle(input logic quiet);
    if (!quiet && $urandom_range(99) < 30) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0 || busy);
  endtask

  initial begin
    rst = 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    issue(CMD_DISPATCH, 32'd0, 32'd0, 8'd0, 8'd0);
    issue(CMD_ARM_ONESHOT, 32'd0, 32'd0, 8'd0, 8'h00);
    issue(CMD_ARM_PERIODIC, 32'hFFFF_FFF0, 32'h20, 8'd0, 8'hFF);
    maybe_idle(1'b0);
    issue(CMD_ARM_PERIODIC, 32'd5, 32'd0, 8'd0, 8'h5A);
    issue(CMD_ARM_ONESHOT, 32'd0, 32'hFFFF_FFFF, 8'd0, 8'hA5);
    issue(CMD_ARM_PERIODIC, 32'd0, 32'h1234_5678, 8'd0, 8'h3C);
    issue(CMD_DISPATCH, 32'h10, 32'd0, 8'd0, 8'd0);
    issue(CMD_DISPATCH, 32'h10, 32'd0, 8'd0, 8'd0);
    maybe_idle(1'b0);
    issue(CMD_CANCEL, 32'd0, 32'd0, 8'd3, 8'd0);
    issue(CMD_CANCEL, 32'd0, 32'd0, 8'hFF, 8'd0);
    issue(CMD_CANCEL, 32'd0, 32'd0, 8'd4, 8'd0);
    issue(CMD_CANCEL, 32'd0, 32'd0, 8'd2, 8'd0);
    issue(CMD_DISPATCH, 32'h8000_0030, 32'd0, 8'd0, 8'd0);
    issue(CMD_DISPATCH, 32'h8000_002F, 32'd0, 8'd0, 8'd0);
    issue(CMD_ARM_ONESHOT, 32'h7FFF_FFFF, 32'h8000_0000, 8'd0, 8'h81);
    issue(CMD_ARM_PERIODIC, 32'hAAAA_AAAA, 32'h5555_5555, 8'hFF, 8'h7E);
    maybe_idle(1'b0);
    issue(CMD_DISPATCH, 32'hFFFF_FFFF, 32'd0, 8'd0, 8'd0);
    issue(CMD_CANCEL, 32'd0, 32'd0, 8'd1, 8'd0);
    issue(CMD_CANCEL, 32'd0, 32'd0, 8'd2, 8'd0);
    issue(CMD_DISPATCH, 32'd0, 32'd0, 8'd0, 8'd0);

    // start close to the wrap point so the tick count rolls over mid-run
    now_ticks = 32'hFFFF_F000;
    issued = 0;
    while (issued < RANDOM_ITEMS) begin
      calm = (issued >= 100 && issued < 160);
      if (issued == 200) drain();
      now_ticks = now_ticks + $urandom_range(0, 40);
      pick = $urandom_range(99);
      next_item.command = (pick < 30) ? CMD_ARM_ONESHOT :
                          (pick < 50) ? CMD_ARM_PERIODIC :
                          (pick < 65) ? CMD_CANCEL : CMD_DISPATCH;
      next_item.current_time = ($urandom_range(99) < 90) ? now_ticks : 32'($urandom);
      pick = $urandom_range(99);
      next_item.interval = (pick < 70) ? 32'($urandom_range(0, 60)) :
                           (pick < 80) ? 32'd0 :
                           (pick < 90) ? 32'($urandom) :
                           32'h7FFF_FFFF + 32'($urandom_range(0, 2));
      next_item.slot_select  = ($urandom_range(99) < 85) ? 8'($urandom_range(0, 3)) :
                                                          8'($urandom_range(0, 255));
      next_item.callback_tag = 8'($urandom_range(0, 255));
      drive_beat(next_item);
      if (!(next_item.command == CMD_CANCEL && next_item.slot_select >= NUM_SLOTS))
        issued++;
      maybe_idle(calm);
    end

    drain();
    repeat (20) @(posedge clk);
    @(negedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
